### rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising clk outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

### rtl/alm_pkg.sv
// Types, codes and constants of the audio level meter.
`timescale 1ns / 1ps
package alm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DB_W     = 16;
  localparam int LED_W    = 6;
  localparam int HOLD_W   = 8;
  localparam int LOG_ITER  = 16;
  localparam int SQRT_ITER = 16;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd30;

  // 20*log10(2) in Q16
  localparam logic [18:0] K_DB = 19'd394566;
  // 15.0 in Q16, log2 of full scale
  localparam logic [19:0] LOG_TOP = 20'd983040;

  localparam logic signed [17:0] C_SMOOTH = 18'sd5243;
  localparam logic signed [17:0] C_PEAK   = 18'sd65405;
  localparam logic signed [17:0] C_HOLD   = 18'sd65470;

  localparam logic signed [DB_W-1:0] DB_OFFSET = 16'sd4608;
  localparam logic signed [DB_W-1:0] DB_FLOOR  = -16'sd20992;
  localparam logic signed [17:0]     LED_BASE  = 18'sd6400;

  // level selects
  localparam logic [1:0] SEL_PERSIST = 2'd0;
  localparam logic [1:0] SEL_PEAK    = 2'd1;
  localparam logic [1:0] SEL_HOLD    = 2'd2;
  // log operand selects
  localparam logic [1:0] LOG_RMS  = 2'd0;
  localparam logic [1:0] LOG_PK   = 2'd1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic [LED_W-1:0]       persist_led;
    logic [LED_W-1:0]       peak_led;
    logic [LED_W-1:0]       hold_led;
    logic signed [DB_W-1:0] persist_db;
  } out_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACC,
    OP_DIV_MEAN,
    OP_DIV_STEP,
    OP_SQRT_LD,
    OP_SQRT_STEP,
    OP_LOG_LD,
    OP_LOG_SQ,
    OP_LOG_NORM,
    OP_LOG_K,
    OP_LOG_END,
    OP_MUL,
    OP_RND,
    OP_UPDATE,
    OP_LED_LD,
    OP_LED_END,
    OP_OUT
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_MEAN_LD,
    S_MEAN_DIV,
    S_SQRT_LD,
    S_SQRT,
    S_LOG_LD,
    S_LOG_SQ,
    S_LOG_NORM,
    S_LOG_K,
    S_LOG_END,
    S_MUL,
    S_RND,
    S_UPDATE,
    S_LED_LD,
    S_LED_END,
    S_OUT
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
  } status_t;

endpackage

### rtl/alm_ctrl.sv
// Frame-end sequencer: steps the datapath through divide, sqrt, log, update, LED scaling and output.
`timescale 1ns / 1ps
module alm_ctrl #(
  parameter int DIV_STEPS = 44
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  alm_pkg::status_t status,
  output alm_pkg::cmd_t    cmd
);

  localparam int STEP_W = $clog2(DIV_STEPS);

  alm_pkg::state_t state, state_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic [1:0] sel, sel_next;
  logic out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= alm_pkg::S_IDLE;
      cnt       <= '0;
      sel       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
      if (state == alm_pkg::S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    unique case (state)
      alm_pkg::S_IDLE: begin
        if (in_valid && status.frame_end) state_next = alm_pkg::S_MEAN_LD;
      end
      alm_pkg::S_MEAN_LD: begin
        cnt_next   = '0;
        state_next = alm_pkg::S_MEAN_DIV;
      end
      alm_pkg::S_MEAN_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_W'(DIV_STEPS - 1)) state_next = alm_pkg::S_SQRT_LD;
      end
      alm_pkg::S_SQRT_LD: begin
        cnt_next   = '0;
        state_next = alm_pkg::S_SQRT;
      end
      alm_pkg::S_SQRT: begin
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_W'(alm_pkg::SQRT_ITER - 1)) begin
          sel_next   = alm_pkg::LOG_RMS;
          state_next = alm_pkg::S_LOG_LD;
        end
      end
      alm_pkg::S_LOG_LD: begin
        cnt_next   = '0;
        state_next = alm_pkg::S_LOG_SQ;
      end
      alm_pkg::S_LOG_SQ: state_next = alm_pkg::S_LOG_NORM;
      alm_pkg::S_LOG_NORM: begin
        cnt_next = cnt + 1'b1;
        if (cnt == STEP_W'(alm_pkg::LOG_ITER - 1)) state_next = alm_pkg::S_LOG_K;
        else state_next = alm_pkg::S_LOG_SQ;
      end
      alm_pkg::S_LOG_K: state_next = alm_pkg::S_LOG_END;
      alm_pkg::S_LOG_END: begin
        if (sel == alm_pkg::LOG_RMS) begin
          sel_next   = alm_pkg::LOG_PK;
          state_next = alm_pkg::S_LOG_LD;
        end else begin
          sel_next   = alm_pkg::SEL_PERSIST;
          state_next = alm_pkg::S_MUL;
        end
      end
      alm_pkg::S_MUL: state_next = alm_pkg::S_RND;
      alm_pkg::S_RND: begin
        if (sel == alm_pkg::SEL_HOLD) begin
          state_next = alm_pkg::S_UPDATE;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = alm_pkg::S_MUL;
        end
      end
      alm_pkg::S_UPDATE: begin
        sel_next   = alm_pkg::SEL_PERSIST;
        state_next = alm_pkg::S_LED_LD;
      end
      alm_pkg::S_LED_LD: state_next = alm_pkg::S_LED_END;
      alm_pkg::S_LED_END: begin
        if (sel == alm_pkg::SEL_HOLD) begin
          state_next = alm_pkg::S_OUT;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = alm_pkg::S_LED_LD;
        end
      end
      alm_pkg::S_OUT: begin
        if (out_free) state_next = alm_pkg::S_IDLE;
      end
      default: state_next = alm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.sel  = sel;
    in_stall = (state != alm_pkg::S_IDLE);
    unique case (state)
      alm_pkg::S_IDLE:     cmd.op = in_valid ? alm_pkg::OP_ACC : alm_pkg::OP_NONE;
      alm_pkg::S_MEAN_LD:  cmd.op = alm_pkg::OP_DIV_MEAN;
      alm_pkg::S_MEAN_DIV: cmd.op = alm_pkg::OP_DIV_STEP;
      alm_pkg::S_SQRT_LD:  cmd.op = alm_pkg::OP_SQRT_LD;
      alm_pkg::S_SQRT:     cmd.op = alm_pkg::OP_SQRT_STEP;
      alm_pkg::S_LOG_LD:   cmd.op = alm_pkg::OP_LOG_LD;
      alm_pkg::S_LOG_SQ:   cmd.op = alm_pkg::OP_LOG_SQ;
      alm_pkg::S_LOG_NORM: cmd.op = alm_pkg::OP_LOG_NORM;
      alm_pkg::S_LOG_K:    cmd.op = alm_pkg::OP_LOG_K;
      alm_pkg::S_LOG_END:  cmd.op = alm_pkg::OP_LOG_END;
      alm_pkg::S_MUL:      cmd.op = alm_pkg::OP_MUL;
      alm_pkg::S_RND:      cmd.op = alm_pkg::OP_RND;
      alm_pkg::S_UPDATE:   cmd.op = alm_pkg::OP_UPDATE;
      alm_pkg::S_LED_LD:   cmd.op = alm_pkg::OP_LED_LD;
      alm_pkg::S_LED_END:  cmd.op = alm_pkg::OP_LED_END;
      alm_pkg::S_OUT:      cmd.op = out_free ? alm_pkg::OP_OUT : alm_pkg::OP_NONE;
      default:             cmd.op = alm_pkg::OP_NONE;
    endcase
  end

endmodule

### rtl/alm_dp.sv
// Meter datapath: accumulators, mean divider, sqrt, log2, level update and LED scaling.
`timescale 1ns / 1ps
module alm_dp #(
  parameter int MAX_FRAME = 4096,
  parameter int LED_COUNT = 40,
  parameter int SUM_W     = 44,
  parameter int CNT_W     = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  alm_pkg::cmd_t    cmd,
  output alm_pkg::status_t status,
  input  alm_pkg::in_t     in_data,
  input  logic             cfg_we,
  input  logic [alm_pkg::HOLD_W-1:0] cfg_wdata,
  output alm_pkg::out_t    out_data
);

  localparam int DVS_W = CNT_W;
  // LED scale: (x*LED_COUNT/256) / (LED_COUNT-1), the last divide by reciprocal
  localparam int LED_TOP = LED_COUNT - 1;
  localparam int LED_SQ  = LED_TOP * LED_TOP;
  localparam int LED_REC = ((1 << 18) + LED_TOP - 1) / LED_TOP;

  // frame accumulators
  logic [SUM_W-1:0]  square_sum;
  logic [CNT_W-1:0]  sample_count;
  logic signed [15:0] frame_peak;
  // meter state
  logic signed [15:0] persist_level, decay_peak, hold_level;
  logic [alm_pkg::HOLD_W-1:0] hold_count, hold_frames;
  // divider
  logic [DVS_W-1:0] div_rem, div_dvs;
  logic [SUM_W-1:0] div_quo;
  // sqrt
  logic [31:0] sq_v, sq_root, sq_bit;
  // log2
  logic [31:0] log_m;
  logic [61:0] log_prod;
  logic [15:0] log_frac;
  logic [3:0]  log_msb;
  logic        log_zero;
  logic [38:0] log_uk;
  logic signed [15:0] rms_db, peak_db;
  // coefficient multiply
  logic signed [34:0] mq_prod;
  logic signed [18:0] rq [3];
  logic [alm_pkg::LED_W-1:0] led_val [3];
  logic led_zero;
  logic led_sat;
  logic [11:0] led_y;

  // accumulate
  logic signed [31:0] sq_prod;
  logic [CNT_W:0] count_inc;
  assign sq_prod   = in_data.sample * in_data.sample;
  assign count_inc = {1'b0, sample_count} + {{CNT_W{1'b0}}, 1'b1};
  assign status.frame_end = in_data.last || (count_inc == (CNT_W+1)'(MAX_FRAME));

  // divider step
  logic [DVS_W:0] div_shift;
  logic           div_ge;
  assign div_shift = {div_rem, div_quo[SUM_W-1]};
  assign div_ge    = div_shift >= {1'b0, div_dvs};

  // sqrt step
  logic [31:0] sq_trial;
  logic        sq_ge;
  assign sq_trial = sq_root + sq_bit;
  assign sq_ge    = sq_v >= sq_trial;

  // log operand and normalization
  logic [16:0] log_n;
  logic [3:0]  msb_calc;
  logic [31:0] m_init;
  logic [31:0] log_t;
  logic [19:0] log_u;
  logic [39:0] log_rnd;
  logic signed [15:0] db_val;

  assign log_n = (cmd.sel == alm_pkg::LOG_PK) ? {1'b0, frame_peak} : sq_root[16:0];

  always_comb begin
    msb_calc = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (log_n[i]) msb_calc = 4'(i);
    end
  end

  assign m_init  = {16'b0, log_n[15:0]} << (5'd30 - {1'b0, msb_calc});
  assign log_t   = log_prod[61:30];
  assign log_u   = alm_pkg::LOG_TOP - {log_msb, log_frac};
  assign log_rnd = ({1'b0, log_uk} + 40'd8388608) >> 24;
  assign db_val  = log_zero ? alm_pkg::DB_FLOOR
                 : alm_pkg::DB_OFFSET - $signed({1'b0, log_rnd[14:0]});

  // coefficient multiply operands
  logic signed [16:0] mul_a;
  logic signed [17:0] mul_c;
  always_comb begin
    case (cmd.sel)
      alm_pkg::SEL_PERSIST: begin
        mul_a = {rms_db[15], rms_db} - {persist_level[15], persist_level};
        mul_c = alm_pkg::C_SMOOTH;
      end
      alm_pkg::SEL_PEAK: begin
        mul_a = {decay_peak[15], decay_peak};
        mul_c = alm_pkg::C_PEAK;
      end
      default: begin
        mul_a = {hold_level[15], hold_level};
        mul_c = alm_pkg::C_HOLD;
      end
    endcase
  end

  // round half away from zero
  logic [34:0] mq_mag;
  logic [18:0] mq_r;
  assign mq_mag = mq_prod[34] ? 35'(-mq_prod) : 35'(mq_prod);
  assign mq_r   = 19'((mq_mag + 35'd32768) >> 16);

  // hold countdown
  logic [alm_pkg::HOLD_W-1:0] hold_dec;
  assign hold_dec = (hold_count != '0) ? hold_count - 1'b1 : '0;

  // LED operand
  logic signed [15:0] led_lvl;
  logic signed [17:0] led_x;
  logic [23:0] led_scaled;
  logic [30:0] led_prod;
  always_comb begin
    case (cmd.sel)
      alm_pkg::SEL_PERSIST: led_lvl = persist_level;
      alm_pkg::SEL_PEAK:    led_lvl = decay_peak;
      default:              led_lvl = hold_level;
    endcase
  end
  assign led_x      = {{2{led_lvl[15]}}, led_lvl} + alm_pkg::LED_BASE;
  assign led_scaled = 24'(led_x[16:0] * LED_COUNT);
  // exact for led_y below LED_TOP squared
  assign led_prod   = 31'(led_y * LED_REC);

  always_ff @(posedge clk) begin
    if (rst) begin
      square_sum    <= '0;
      sample_count  <= '0;
      frame_peak    <= '0;
      persist_level <= '0;
      decay_peak    <= '0;
      hold_level    <= '0;
      hold_count    <= '0;
      hold_frames   <= alm_pkg::HOLD_RESET;
    end else begin
      if (cfg_we) hold_frames <= cfg_wdata;
      case (cmd.op)
        alm_pkg::OP_ACC: begin
          square_sum   <= square_sum + SUM_W'(sq_prod[30:0]);
          sample_count <= count_inc[CNT_W-1:0];
          if (in_data.sample > frame_peak) frame_peak <= in_data.sample;
        end
        alm_pkg::OP_UPDATE: begin
          persist_level <= persist_level + rq[0][15:0];
          if (peak_db > decay_peak) decay_peak <= peak_db;
          else decay_peak <= rq[1][15:0];
          if (peak_db > hold_level) begin
            hold_level <= peak_db;
            hold_count <= hold_frames;
          end else begin
            hold_count <= hold_dec;
            if (hold_dec == '0) hold_level <= rq[2][15:0];
          end
          square_sum   <= '0;
          sample_count <= '0;
          frame_peak   <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      alm_pkg::OP_DIV_MEAN: begin
        div_rem <= '0;
        div_quo <= square_sum;
        div_dvs <= DVS_W'(sample_count);
      end
      alm_pkg::OP_DIV_STEP: begin
        div_rem <= div_ge ? DVS_W'(div_shift - {1'b0, div_dvs}) : div_shift[DVS_W-1:0];
        div_quo <= {div_quo[SUM_W-2:0], div_ge};
      end
      alm_pkg::OP_SQRT_LD: begin
        sq_v    <= div_quo[31:0];
        sq_root <= '0;
        sq_bit  <= 32'h4000_0000;
      end
      alm_pkg::OP_SQRT_STEP: begin
        if (sq_ge) begin
          sq_v    <= sq_v - sq_trial;
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      alm_pkg::OP_LOG_LD: begin
        log_zero <= (log_n == '0);
        log_msb  <= msb_calc;
        log_m    <= m_init;
        log_frac <= '0;
      end
      alm_pkg::OP_LOG_SQ: log_prod <= log_m * log_m;
      alm_pkg::OP_LOG_NORM: begin
        log_frac <= {log_frac[14:0], log_t[31]};
        log_m    <= log_t[31] ? (log_t >> 1) : log_t;
      end
      alm_pkg::OP_LOG_K: log_uk <= log_u * alm_pkg::K_DB;
      alm_pkg::OP_LOG_END: begin
        if (cmd.sel == alm_pkg::LOG_PK) peak_db <= db_val;
        else rms_db <= db_val;
      end
      alm_pkg::OP_MUL: mq_prod <= mul_a * mul_c;
      alm_pkg::OP_RND: rq[cmd.sel] <= mq_prod[34] ? -$signed(mq_r) : $signed(mq_r);
      alm_pkg::OP_LED_LD: begin
        led_zero <= (led_x <= 18'sd0);
        led_sat  <= (led_scaled[23:8] >= 16'(LED_SQ));
        led_y    <= led_scaled[19:8];
      end
      alm_pkg::OP_LED_END: begin
        if (led_zero) led_val[cmd.sel] <= '0;
        else if (led_sat) led_val[cmd.sel] <= alm_pkg::LED_W'(LED_TOP);
        else led_val[cmd.sel] <= led_prod[18 +: alm_pkg::LED_W];
      end
      alm_pkg::OP_OUT: begin
        out_data.persist_led <= led_val[0];
        out_data.peak_led    <= led_val[1];
        out_data.hold_led    <= led_val[2];
        out_data.persist_db  <= persist_level;
      end
      default: ;
    endcase
  end

endmodule

### rtl/audio_level_meter_peak_hold_core.sv
// Throughput: one sample per cycle inside a frame; the last sample of a frame is
//   followed by the serial mean divide (SUM_W steps), sqrt and two log2 passes.
// The mean divide and the two 16-step log2 loops set the frame-end time; input
//   stays stalled longer while the previous readout still waits on out_stall.
// Reset (rst, synchronous): accumulators and levels zero, hold_frames = 30.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module audio_level_meter_peak_hold_core #(
  parameter int MAX_FRAME = 4096,
  parameter int LED_COUNT = 40
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  alm_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output alm_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [alm_pkg::HOLD_W-1:0] cfg_wdata
);

  // sum of squares holds MAX_FRAME full-scale Q2.30 squares
  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = $clog2(MAX_FRAME) + 32;

  alm_pkg::cmd_t    cmd;
  alm_pkg::status_t status;

  // sequencer: accepts samples in idle, then walks the frame-end math
  alm_ctrl #(
    .DIV_STEPS(SUM_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath also owns the hold_frames register and the output transaction register
  alm_dp #(
    .MAX_FRAME(MAX_FRAME),
    .LED_COUNT(LED_COUNT),
    .SUM_W    (SUM_W),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_data (out_data)
  );

  // output register is only reloaded when free
  `ASSERT_IMPL(a_out_load_free, cmd.op == alm_pkg::OP_OUT, !out_valid || !out_stall)
  // any frame-end work holds off new samples
  `ASSERT_IMPL(a_busy_stall, cmd.op != alm_pkg::OP_ACC && cmd.op != alm_pkg::OP_NONE, in_stall)
  // a load always presents a transaction next cycle
  `ASSERT_NEXT(a_out_shown, cmd.op == alm_pkg::OP_OUT, out_valid)
  // LED positions stay on the bar
  `ASSERT_IMPL(a_led_range, out_valid, out_data.persist_led <= 6'(LED_COUNT - 1) && out_data.peak_led <= 6'(LED_COUNT - 1) && out_data.hold_led <= 6'(LED_COUNT - 1))

endmodule
